### hw/rtl/dtmf_pkg.sv
package dtmf_pkg;

  typedef struct packed {
    logic        command;
    logic [3:0]  digit;
    logic [15:0] tone_ms;
  } req_t;

  typedef struct packed {
    logic [7:0] pwm_level;
    logic       tone_active;
    logic       tone_done;
  } rsp_t;

  typedef struct packed {
    logic [15:0] phase_high;
    logic [15:0] phase_low;
    logic [7:0]  step_high;
    logic [7:0]  step_low;
    logic [22:0] tick_count;
    logic [22:0] segment_limit;
    logic [1:0]  note_index;
    logic        tune_falling;
    logic        tune_mode;
    logic        output_on;
  } state_t;

  typedef struct packed {
    logic [1:0] col;
    logic [1:0] row;
  } key_pos_t;

  localparam int unsigned TableSize    = 128;
  localparam int unsigned TableBits    = $clog2(TableSize);
  localparam int unsigned FractionBits = 8;

  // register map, word index = paddr[4:2]
  localparam logic [2:0] RegRowSteps       = 3'd0;
  localparam logic [2:0] RegColumnSteps    = 3'd1;
  localparam logic [2:0] RegBeepSteps      = 3'd2;
  localparam logic [2:0] RegTuneSteps      = 3'd3;
  localparam logic [2:0] RegTicksPerSecond = 3'd4;

  localparam logic [15:0] TicksPerSecondReset = 16'd31250;

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;

  localparam logic [3:0] DigitZero     = 4'd0;
  localparam logic [3:0] DigitStar     = 4'd10;
  localparam logic [3:0] DigitHash     = 4'd11;
  localparam logic [3:0] DigitBeep     = 4'd12;
  localparam logic [3:0] DigitLowBeep  = 4'd13;
  localparam logic [3:0] DigitTuneUp   = 4'd14;
  localparam logic [3:0] DigitTuneDown = 4'd15;

  // x/3 = (x * 43691) >> 17, exact for 16-bit x
  localparam logic [16:0] ThirdRecip = 17'd43691;
  localparam int unsigned ThirdShift = 17;
  // (p>>3)/125 = ((p>>3) * 549755814) >> 36, exact for 29-bit operands
  localparam logic [29:0] MilliRecip = 30'd549755814;
  localparam int unsigned MilliShift = 36;

  localparam logic [6:0] SineTable [128] = '{
    7'd64,  7'd67,  7'd70,  7'd73,  7'd76,  7'd79,  7'd82,  7'd85,
    7'd88,  7'd91,  7'd94,  7'd96,  7'd99,  7'd102, 7'd104, 7'd106,
    7'd109, 7'd111, 7'd113, 7'd115, 7'd117, 7'd118, 7'd120, 7'd121,
    7'd123, 7'd124, 7'd125, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
    7'd127, 7'd127, 7'd127, 7'd127, 7'd126, 7'd126, 7'd125, 7'd124,
    7'd123, 7'd121, 7'd120, 7'd118, 7'd117, 7'd115, 7'd113, 7'd111,
    7'd109, 7'd106, 7'd104, 7'd102, 7'd99,  7'd96,  7'd94,  7'd91,
    7'd88,  7'd85,  7'd82,  7'd79,  7'd76,  7'd73,  7'd70,  7'd67,
    7'd64,  7'd60,  7'd57,  7'd54,  7'd51,  7'd48,  7'd45,  7'd42,
    7'd39,  7'd36,  7'd33,  7'd31,  7'd28,  7'd25,  7'd23,  7'd21,
    7'd18,  7'd16,  7'd14,  7'd12,  7'd10,  7'd9,   7'd7,   7'd6,
    7'd4,   7'd3,   7'd2,   7'd1,   7'd1,   7'd0,   7'd0,   7'd0,
    7'd0,   7'd0,   7'd0,   7'd0,   7'd1,   7'd1,   7'd2,   7'd3,
    7'd4,   7'd6,   7'd7,   7'd9,   7'd10,  7'd12,  7'd14,  7'd16,
    7'd18,  7'd21,  7'd23,  7'd25,  7'd28,  7'd31,  7'd33,  7'd36,
    7'd39,  7'd42,  7'd45,  7'd48,  7'd51,  7'd54,  7'd57,  7'd60
  };

  function automatic logic [6:0] sine_at(logic [TableBits-1:0] idx);
    return SineTable[idx];
  endfunction

  function automatic logic [7:0] byte_sel(logic [31:0] word, logic [1:0] n);
    return word[{n, 3'b000} +: 8];
  endfunction

  // keypad position: column selects the high tone, row the low tone
  function automatic key_pos_t key_pos(logic [3:0] digit);
    key_pos_t kp;
    case (digit)
      DigitZero: kp = '{col: 2'd1, row: 2'd3};
      4'd1:      kp = '{col: 2'd0, row: 2'd0};
      4'd2:      kp = '{col: 2'd1, row: 2'd0};
      4'd3:      kp = '{col: 2'd2, row: 2'd0};
      4'd4:      kp = '{col: 2'd0, row: 2'd1};
      4'd5:      kp = '{col: 2'd1, row: 2'd1};
      4'd6:      kp = '{col: 2'd2, row: 2'd1};
      4'd7:      kp = '{col: 2'd0, row: 2'd2};
      4'd8:      kp = '{col: 2'd1, row: 2'd2};
      4'd9:      kp = '{col: 2'd2, row: 2'd2};
      DigitStar: kp = '{col: 2'd0, row: 2'd3};
      DigitHash: kp = '{col: 2'd2, row: 2'd3};
      default:   kp = '{col: 2'd0, row: 2'd0};
    endcase
    return kp;
  endfunction

endpackage

### hw/rtl/dtmf_ram.sv
module dtmf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hw/rtl/dtmf_tone_synthesizer_unit.sv
// Tick request: result passes the front, execute and output registers; one tick per cycle
// sustained while the output is not stalled. Start request: input ready stays low while the
// duration is scaled to ticks through three registered multiplies.
// Tone state lives in a one-entry RAM, read on entry to the execute stage and written back,
// with a forward of the previous write. Reset (rst_ni low, async) silences the output,
// zeroes the tone state and loads ticks_per_second with 31250.
module dtmf_tone_synthesizer_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dtmf_pkg::req_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dtmf_pkg::rsp_t       out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // configuration
  logic [31:0] row_steps_q;
  logic [23:0] column_steps_q;
  logic [15:0] beep_steps_q;
  logic [23:0] tune_steps_q;
  logic [15:0] tps_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_steps_q    <= '0;
      column_steps_q <= '0;
      beep_steps_q   <= '0;
      tune_steps_q   <= '0;
      tps_q          <= dtmf_pkg::TicksPerSecondReset;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        dtmf_pkg::RegRowSteps:       row_steps_q    <= pwdata;
        dtmf_pkg::RegColumnSteps:    column_steps_q <= pwdata[23:0];
        dtmf_pkg::RegBeepSteps:      beep_steps_q   <= pwdata[15:0];
        dtmf_pkg::RegTuneSteps:      tune_steps_q   <= pwdata[23:0];
        dtmf_pkg::RegTicksPerSecond: tps_q          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      dtmf_pkg::RegRowSteps:       prdata = row_steps_q;
      dtmf_pkg::RegColumnSteps:    prdata = {8'b0, column_steps_q};
      dtmf_pkg::RegBeepSteps:      prdata = {16'b0, beep_steps_q};
      dtmf_pkg::RegTuneSteps:      prdata = {8'b0, tune_steps_q};
      dtmf_pkg::RegTicksPerSecond: prdata = {16'b0, tps_q};
      default:                     prdata = '0;
    endcase
  end

  // front stage: holds a request, scales a start duration to ticks
  logic             f_valid_q;
  dtmf_pkg::req_t   f_req_q;
  logic [1:0]       f_step_q;
  logic             f_is_tune;
  logic             f_done;
  logic             f_move;
  logic             in_acc;
  logic [32:0]      third_prod;
  logic [15:0]      ms_adj_q;
  logic [31:0]      prod1_q;
  logic [58:0]      prod2_q;

  logic             b_valid_q;
  logic             b_fire;
  logic             b_free;

  assign f_is_tune  = (f_req_q.digit == dtmf_pkg::DigitTuneUp) ||
                      (f_req_q.digit == dtmf_pkg::DigitTuneDown);
  assign f_done     = (f_req_q.command == dtmf_pkg::CmdTick) || (f_step_q == 2'd3);
  assign f_move     = f_valid_q && f_done && b_free;
  assign in_ready_o = !f_valid_q || f_move;
  assign in_acc     = in_valid_i && in_ready_o;
  assign third_prod = f_req_q.tone_ms * dtmf_pkg::ThirdRecip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      f_step_q  <= '0;
    end else if (in_acc) begin
      f_valid_q <= 1'b1;
      f_step_q  <= '0;
    end else if (f_move) begin
      f_valid_q <= 1'b0;
    end else if (f_valid_q && !f_done) begin
      f_step_q  <= f_step_q + 2'd1;
    end
  end

  // free-running multiply chain; each register is fed by the one before it
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f_req_q <= in_data_i;
    end
    ms_adj_q <= f_is_tune ? third_prod[dtmf_pkg::ThirdShift +: 16] : f_req_q.tone_ms;
    prod1_q  <= ms_adj_q * tps_q;
    prod2_q  <= prod1_q[31:3] * dtmf_pkg::MilliRecip;
  end

  // execute stage
  logic             b_command_q;
  logic [3:0]       b_digit_q;
  logic [22:0]      b_limit_q;
  logic             out_valid_q;
  dtmf_pkg::rsp_t   out_q;

  assign b_fire = b_valid_q && (!out_valid_q || out_ready_i);
  assign b_free = !b_valid_q || b_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (f_move) begin
      b_valid_q <= 1'b1;
    end else if (b_fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_move) begin
      b_command_q <= f_req_q.command;
      b_digit_q   <= f_req_q.digit;
      b_limit_q   <= prod2_q[dtmf_pkg::MilliShift +: 23];
    end
  end

  // state memory with forward of the write issued alongside the read
  dtmf_pkg::state_t st_rdata;
  dtmf_pkg::state_t st_next;
  dtmf_pkg::state_t fwd_data_q;
  dtmf_pkg::state_t cur;
  logic             fwd_sel_q;
  logic             st_init_q;
  logic             rd_init_q;

  dtmf_ram #(
    .Width($bits(dtmf_pkg::state_t)),
    .Depth(1)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (b_fire),
    .waddr_i('0),
    .wdata_i(st_next),
    .re_i   (f_move),
    .raddr_i('0),
    .rdata_o(st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_sel_q <= 1'b0;
      st_init_q <= 1'b0;
      rd_init_q <= 1'b0;
    end else begin
      if (b_fire) begin
        st_init_q <= 1'b1;
      end
      if (f_move) begin
        fwd_sel_q <= b_fire;
        rd_init_q <= st_init_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_move) begin
      fwd_data_q <= st_next;
    end
  end

  assign cur = fwd_sel_q ? fwd_data_q : (rd_init_q ? st_rdata : '0);

  // tone arithmetic
  dtmf_pkg::key_pos_t kp;
  dtmf_pkg::rsp_t     rsp;
  logic [15:0] ph_high;
  logic [15:0] ph_low;
  logic [6:0]  sin_a;
  logic [6:0]  sin_b;
  logic        low_on;
  logic [8:0]  mix_a;
  logic [8:0]  mix_b;
  logic [8:0]  level;
  logic [22:0] tc;
  logic        seg_end;
  logic [1:0]  next_note;
  logic [1:0]  note_sel;
  logic [1:0]  start_sel;
  logic        start_falling;

  assign kp        = dtmf_pkg::key_pos(b_digit_q);
  assign ph_high   = cur.phase_high + {8'b0, cur.step_high};
  assign ph_low    = cur.phase_low + {8'b0, cur.step_low};
  assign sin_a     = dtmf_pkg::sine_at(ph_high[dtmf_pkg::FractionBits +: dtmf_pkg::TableBits]);
  assign sin_b     = dtmf_pkg::sine_at(ph_low[dtmf_pkg::FractionBits +: dtmf_pkg::TableBits]);
  assign low_on    = cur.step_low != 8'd0;
  // no low tone: high tone doubled
  assign mix_a     = low_on ? {2'b0, sin_a} : {1'b0, sin_a, 1'b0};
  assign mix_b     = low_on ? {2'b0, sin_b} : 9'd0;
  assign level     = mix_a + mix_b - (mix_b >> 2);
  assign tc        = cur.tick_count + 23'd1;
  assign seg_end   = cur.output_on && (tc > cur.segment_limit);
  assign next_note = cur.note_index + 2'd1;
  assign note_sel  = cur.tune_falling ? (2'd2 - next_note) : next_note;
  assign start_falling = b_digit_q == dtmf_pkg::DigitTuneDown;
  assign start_sel = start_falling ? 2'd2 : 2'd0;

  always_comb begin
    st_next = cur;
    rsp     = '0;
    if (b_command_q == dtmf_pkg::CmdStart) begin
      st_next.tune_mode     = 1'b0;
      st_next.tune_falling  = 1'b0;
      st_next.note_index    = '0;
      st_next.step_low      = '0;
      st_next.segment_limit = b_limit_q;
      st_next.tick_count    = '0;
      st_next.output_on     = 1'b1;
      case (b_digit_q)
        dtmf_pkg::DigitBeep: begin
          st_next.step_high = beep_steps_q[7:0];
        end
        dtmf_pkg::DigitLowBeep: begin
          st_next.step_high = beep_steps_q[15:8];
        end
        dtmf_pkg::DigitTuneUp, dtmf_pkg::DigitTuneDown: begin
          st_next.tune_mode    = 1'b1;
          st_next.tune_falling = start_falling;
          st_next.step_high    = dtmf_pkg::byte_sel({8'b0, tune_steps_q}, start_sel);
        end
        default: begin
          st_next.step_high = dtmf_pkg::byte_sel({8'b0, column_steps_q}, kp.col);
          st_next.step_low  = dtmf_pkg::byte_sel(row_steps_q, kp.row);
        end
      endcase
      rsp.tone_active = 1'b1;
    end else begin
      st_next.phase_high = ph_high;
      if (low_on) begin
        st_next.phase_low = ph_low;
      end
      st_next.tick_count = tc;
      if (seg_end) begin
        if (cur.tune_mode && (cur.note_index < 2'd2)) begin
          st_next.note_index = next_note;
          st_next.step_high  = dtmf_pkg::byte_sel({8'b0, tune_steps_q}, note_sel);
          st_next.tick_count = '0;
        end else begin
          st_next.output_on  = 1'b0;
          st_next.tune_mode  = 1'b0;
          st_next.note_index = '0;
          st_next.step_high  = '0;
          st_next.step_low   = '0;
          rsp.tone_done      = 1'b1;
        end
      end
      rsp.tone_active = cur.output_on;
      rsp.pwm_level   = cur.output_on ? level[7:0] : 8'd0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sim/dtmf_tone_synthesizer_unit_tb.sv
module dtmf_tone_synthesizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtmf_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int NumDirected = 25;
  localparam int TunedFrom   = 7;
  localparam int PhaseItems  = 340;
  localparam int QuietTail   = 120;
  localparam logic Lit  = 1'b1;
  localparam logic Pred = 1'b0;

  typedef struct packed {
    req_t req;
    logic lit;
    rsp_t want;
  } script_row_t;

  // first rows run on reset settings (all steps zero), the rest on the tuned ones
  localparam script_row_t Script [NumDirected] = '{
    {CmdTick,  4'd0,          16'd0,     Lit,  8'd0,   1'b0, 1'b0},
    {CmdStart, DigitZero,     16'd0,     Lit,  8'd0,   1'b1, 1'b0},
    {CmdTick,  4'd0,          16'd0,     Lit,  8'd128, 1'b1, 1'b1},
    {CmdTick,  4'd0,          16'd0,     Lit,  8'd0,   1'b0, 1'b0},
    {CmdStart, DigitTuneDown, 16'hFFFF,  Lit,  8'd0,   1'b1, 1'b0},
    {CmdStart, DigitHash,     16'd0,     Lit,  8'd0,   1'b1, 1'b0},
    {CmdTick,  4'd0,          16'd0,     Lit,  8'd128, 1'b1, 1'b1},
    {CmdStart, 4'd1,          16'd1,     Pred, 10'd0},
    {CmdTick,  4'd0,          16'd0,     Pred, 10'd0},
    {CmdStart, 4'd5,          16'd0,     Pred, 10'd0},
    {CmdTick,  4'd0,          16'd0,     Pred, 10'd0},
    {CmdStart, 4'd9,          16'd1,     Pred, 10'd0},
    {CmdTick,  4'd15,         16'hFFFF,  Pred, 10'd0},
    {CmdStart, DigitStar,     16'd1,     Pred, 10'd0},
    {CmdTick,  4'd0,          16'd0,     Pred, 10'd0},
    {CmdStart, DigitBeep,     16'd0,     Pred, 10'd0},
    {CmdTick,  4'd0,          16'd0,     Pred, 10'd0},
    {CmdStart, DigitLowBeep,  16'd0,     Pred, 10'd0},
    {CmdTick,  4'd0,          16'd0,     Pred, 10'd0},
    {CmdStart, DigitTuneUp,   16'hFFFF,  Pred, 10'd0},
    {CmdTick,  4'd0,          16'd0,     Pred, 10'd0},
    {CmdStart, DigitTuneUp,   16'd2,     Pred, 10'd0},
    {CmdTick,  4'd0,          16'd0,     Pred, 10'd0},
    {CmdTick,  4'd0,          16'd0,     Pred, 10'd0},
    {CmdTick,  4'd0,          16'd0,     Pred, 10'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  rsp_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dtmf_tone_synthesizer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register copies
  logic [31:0] row_cfg  = '0;
  logic [23:0] col_cfg  = '0;
  logic [15:0] beep_cfg = '0;
  logic [23:0] tune_cfg = '0;
  logic [15:0] rate_cfg = TicksPerSecondReset;

  // tone state
  logic [15:0] hi_phase = '0;
  logic [15:0] lo_phase = '0;
  logic [7:0]  hi_step = '0;
  logic [7:0]  lo_step = '0;
  logic [22:0] tick_cnt = '0;
  logic [22:0] seg_len = '0;
  logic [1:0]  note_no = '0;
  logic        tune_down = 1'b0;
  logic        tune_on = 1'b0;
  logic        tone_on = 1'b0;

  rsp_t due_samples [$];
  rsp_t head;
  int   fail_count = 0;
  int   req_count = 0;
  int   quiet_cycles = 0;
  int   src_pct = 0;
  int   sink_pct = 0;
  int   stall_left = 0;

  function automatic logic [6:0] wave_at(logic [15:0] ph);
    return SineTable[ph[FractionBits +: TableBits]];
  endfunction

  function automatic logic [7:0] pick_byte(logic [31:0] w, int unsigned n);
    return w[8*n +: 8];
  endfunction

  function automatic logic [22:0] ms_ticks(logic [15:0] ms);
    logic [31:0] prod;
    logic [31:0] q;
    prod = {16'd0, ms} * {16'd0, rate_cfg};
    q = prod / 1000;
    return q[22:0];
  endfunction

  function automatic logic [7:0] tune_note_step();
    int unsigned n;
    n = tune_down ? 2 - note_no : note_no;
    return pick_byte({8'd0, tune_cfg}, n);
  endfunction

  task automatic synth_step(input req_t r, output rsp_t y);
    int unsigned d;
    int unsigned col;
    int unsigned row;
    logic [15:0] ms;
    logic [8:0]  a;
    logic [6:0]  b;
    logic [9:0]  mix;
    logic        was_on;
    logic        done;
    d = r.digit;
    ms = r.tone_ms;
    if (r.command == CmdStart) begin
      tune_on = 1'b0;
      tune_down = 1'b0;
      note_no = '0;
      lo_step = '0;
      if (r.digit <= DigitHash) begin
        if (r.digit == DigitZero) begin
          col = 1; row = 3;
        end else if (r.digit == DigitStar) begin
          col = 0; row = 3;
        end else if (r.digit == DigitHash) begin
          col = 2; row = 3;
        end else begin
          col = (d - 1) % 3;
          row = (d - 1) / 3;
        end
        hi_step = pick_byte({8'd0, col_cfg}, col);
        lo_step = pick_byte(row_cfg, row);
      end else if (r.digit == DigitBeep) begin
        hi_step = beep_cfg[7:0];
      end else if (r.digit == DigitLowBeep) begin
        hi_step = beep_cfg[15:8];
      end else begin
        tune_on = 1'b1;
        tune_down = (r.digit == DigitTuneDown);
        ms = ms / 16'd3;
        hi_step = tune_note_step();
      end
      seg_len = ms_ticks(ms);
      tick_cnt = '0;
      tone_on = 1'b1;
      y = '{pwm_level: 8'd0, tone_active: 1'b1, tone_done: 1'b0};
    end else begin
      was_on = tone_on;
      done = 1'b0;
      b = '0;
      hi_phase = hi_phase + hi_step;
      a = {2'b00, wave_at(hi_phase)};
      if (lo_step != 0) begin
        lo_phase = lo_phase + lo_step;
        b = wave_at(lo_phase);
      end else begin
        a = a << 1;
      end
      mix = a + b - (b >> 2);
      tick_cnt = tick_cnt + 1'b1;
      if (tone_on && tick_cnt > seg_len) begin
        if (tune_on && note_no < 2) begin
          note_no = note_no + 1'b1;
          hi_step = tune_note_step();
          tick_cnt = '0;
        end else begin
          done = 1'b1;
          tone_on = 1'b0;
          tune_on = 1'b0;
          note_no = '0;
          hi_step = '0;
          lo_step = '0;
        end
      end
      y.pwm_level = was_on ? mix[7:0] : 8'd0;
      y.tone_active = was_on;
      y.tone_done = done;
    end
  endtask

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (due_samples.size() == 0) begin
        note_fail($sformatf("unexpected sample %h", out_data));
      end else begin
        head = due_samples.pop_front();
        if (out_data.pwm_level !== head.pwm_level || out_data.tone_active !== head.tone_active
            || out_data.tone_done !== head.tone_done)
          note_fail($sformatf("level/active/done exp %0d/%0d/%0d got %0d/%0d/%0d",
                              head.pwm_level, head.tone_active, head.tone_done,
                              out_data.pwm_level, out_data.tone_active, out_data.tone_done));
      end
    end
  end

  // output back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
      stall_left <= $urandom_range(1, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic drive_req(input req_t r, input logic use_lit, input rsp_t lit);
    rsp_t y;
    if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    synth_step(r, y);
    due_samples.push_back(use_lit ? lit : y);
    in_valid <= 1'b1;
    in_data <= r;
    req_count++;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wd,
                          output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    logic [31:0] kept;
    logic [31:0] rd;
    case (idx)
      RegRowSteps: begin
        row_cfg = v;
        kept = v;
      end
      RegColumnSteps: begin
        col_cfg = v[23:0];
        kept = {8'd0, v[23:0]};
      end
      RegBeepSteps: begin
        beep_cfg = v[15:0];
        kept = {16'd0, v[15:0]};
      end
      RegTuneSteps: begin
        tune_cfg = v[23:0];
        kept = {8'd0, v[23:0]};
      end
      default: begin
        rate_cfg = v[15:0];
        kept = {16'd0, v[15:0]};
      end
    endcase
    apb_xfer(1'b1, idx, v, rd);
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== kept) note_fail($sformatf("reg %0d read exp %h got %h", idx, kept, rd));
  endtask

  task automatic set_config(input logic [31:0] row, input logic [31:0] col,
                            input logic [31:0] beep, input logic [31:0] tune,
                            input logic [31:0] rate);
    write_reg(RegRowSteps, row);
    write_reg(RegColumnSteps, col);
    write_reg(RegBeepSteps, beep);
    write_reg(RegTuneSteps, tune);
    write_reg(RegTicksPerSecond, rate);
  endtask

  // mostly start-then-ticks sequences that play a tone out, some cut short, some noise
  task automatic play_random(input int count, input logic quiet_tail);
    req_t r;
    int   stop_at;
    int   cap;
    int   cut;
    int   n;
    stop_at = req_count + count;
    while (req_count < stop_at) begin
      if (quiet_tail && req_count >= stop_at - QuietTail) begin
        src_pct = 0;
        sink_pct = 0;
      end else if ($urandom_range(0, 99) < 30) begin
        src_pct = 0;
        sink_pct = 0;
      end else begin
        src_pct = 10;
        sink_pct = 8;
      end
      if ($urandom_range(0, 99) < 15) begin
        r = req_t'($urandom);
        drive_req(r, 1'b0, '0);
      end else begin
        r.command = CmdStart;
        r.digit = 4'($urandom_range(0, 15));
        cap = 64000 / rate_cfg;
        if (cap < 2) cap = 2;
        if (r.digit >= DigitTuneUp) cap = cap * 3;
        if (cap > 65535) cap = 65535;
        r.tone_ms = 16'($urandom_range(0, cap));
        drive_req(r, 1'b0, '0);
        cut = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 8) : 500;
        n = 0;
        r.command = CmdTick;
        while (tone_on && n < cut) begin
          r.digit = 4'($urandom_range(0, 15));
          r.tone_ms = 16'($urandom);
          drive_req(r, 1'b0, '0);
          n++;
        end
        repeat ($urandom_range(0, 3)) begin
          r.digit = 4'($urandom_range(0, 15));
          r.tone_ms = 16'($urandom);
          drive_req(r, 1'b0, '0);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      if (i == TunedFrom) begin
        drain();
        set_config(32'h1D1B1917, 32'h2F2B27, 32'h1020, 32'h312719, 32'd3000);
      end
      drive_req(Script[i].req, Script[i].lit, Script[i].want);
    end

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: set_config($urandom, $urandom, $urandom, $urandom, 32'd8000);
        1: set_config(32'hFFFFFFFF, 32'hFFFFFF, 32'hFFFF, 32'hFFFFFF, 32'hFFFF);
        2: set_config('0, '0, '0, '0, 32'd1);
        3: set_config($urandom & 32'hFF00FFFF, $urandom & 32'h00FFFF, $urandom & 32'hFF00,
                      $urandom & 32'hFFFF00, $urandom_range(1, 65535));
        default: set_config($urandom, $urandom, $urandom, $urandom, 32'd31250);
      endcase
      play_random(PhaseItems, ph == 4);
    end

    src_pct = 0;
    sink_pct = 0;
    drain();
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
